// ===== hdl/pidci_pkg.sv =====
// Shared types and constants for the PID controller with conditional integration.
package pidci_pkg;

	localparam int GAIN_WIDTH = 24;
	localparam int GAIN_FRAC  = 24;	// fraction bits of a gain-times-term product
	localparam int OUT_WIDTH  = 12;
	localparam int REG_IDX_WIDTH = 3;

	typedef enum logic [REG_IDX_WIDTH-1:0] {
		REG_KP_GAIN  = 3'd0,
		REG_KI_GAIN  = 3'd1,
		REG_KD_GAIN  = 3'd2,
		REG_SETPOINT = 3'd3,
		REG_OUT_MAX  = 3'd4,
		REG_OUT_MIN  = 3'd5,
		REG_OUT_BASE = 3'd6
	} reg_idx_t;

	localparam logic [GAIN_WIDTH-1:0] KP_GAIN_RST  = 24'd1638400;
	localparam logic [GAIN_WIDTH-1:0] KI_GAIN_RST  = 24'd819;
	localparam logic [GAIN_WIDTH-1:0] KD_GAIN_RST  = 24'd81920;
	localparam int                    SETPOINT_RST = 16384;
	localparam logic [OUT_WIDTH-1:0]  OUT_MAX_RST  = 12'd2000;
	localparam logic [OUT_WIDTH-1:0]  OUT_MIN_RST  = 12'd1000;
	localparam logic [OUT_WIDTH-1:0]  OUT_BASE_RST = 12'd1500;

	// gains, output limits and output base (setpoint width follows the sample width)
	typedef struct packed {
		logic [GAIN_WIDTH-1:0] kp_gain;
		logic [GAIN_WIDTH-1:0] ki_gain;
		logic [GAIN_WIDTH-1:0] kd_gain;
		logic [OUT_WIDTH-1:0]  out_max;
		logic [OUT_WIDTH-1:0]  out_min;
		logic [OUT_WIDTH-1:0]  out_base;
	} ctrl_cfg_t;

endpackage

// ===== hdl/pidci_cfg_regs.sv =====
// Configuration register file: gains, setpoint and drive limits.
module pidci_cfg_regs
	import pidci_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 16,
	parameter int CFG_DATA_WIDTH = 24
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	input  logic [REG_IDX_WIDTH-1:0]        cfg_index,
	input  logic [CFG_DATA_WIDTH-1:0]       cfg_data,
	output ctrl_cfg_t                       cfg,
	output logic signed [SAMPLE_WIDTH-1:0]  setpoint
);

	ctrl_cfg_t                      cfg_q;
	logic signed [SAMPLE_WIDTH-1:0] setpoint_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.kp_gain  <= KP_GAIN_RST;
			cfg_q.ki_gain  <= KI_GAIN_RST;
			cfg_q.kd_gain  <= KD_GAIN_RST;
			cfg_q.out_max  <= OUT_MAX_RST;
			cfg_q.out_min  <= OUT_MIN_RST;
			cfg_q.out_base <= OUT_BASE_RST;
			setpoint_q     <= SAMPLE_WIDTH'(SETPOINT_RST);
		end else if (cfg_valid) begin
			unique case (reg_idx_t'(cfg_index))
				REG_KP_GAIN:  cfg_q.kp_gain  <= cfg_data[GAIN_WIDTH-1:0];
				REG_KI_GAIN:  cfg_q.ki_gain  <= cfg_data[GAIN_WIDTH-1:0];
				REG_KD_GAIN:  cfg_q.kd_gain  <= cfg_data[GAIN_WIDTH-1:0];
				REG_SETPOINT: setpoint_q     <= cfg_data[SAMPLE_WIDTH-1:0];
				REG_OUT_MAX:  cfg_q.out_max  <= cfg_data[OUT_WIDTH-1:0];
				REG_OUT_MIN:  cfg_q.out_min  <= cfg_data[OUT_WIDTH-1:0];
				REG_OUT_BASE: cfg_q.out_base <= cfg_data[OUT_WIDTH-1:0];
				default: ;	// unused index: dropped
			endcase
		end
	end

	assign cfg      = cfg_q;
	assign setpoint = setpoint_q;

endmodule

// ===== hdl/pidci_datapath.sv =====
// Single-pass PID datapath with the error, accumulator and last-output state.
module pidci_datapath
	import pidci_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 16,
	parameter int ACCUM_WIDTH = 32
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            step,
	input  logic signed [SAMPLE_WIDTH-1:0]  measurement,
	input  logic                            hold,
	input  ctrl_cfg_t                       cfg,
	input  logic signed [SAMPLE_WIDTH-1:0]  setpoint,
	output logic [OUT_WIDTH-1:0]            drive_next
);

	localparam int EW = SAMPLE_WIDTH + 1;	// error
	localparam int DFW = SAMPLE_WIDTH + 2;	// difference
	localparam int SUMW = ((ACCUM_WIDTH > EW) ? ACCUM_WIDTH : EW) + 1;
	localparam int PW = ((ACCUM_WIDTH > DFW) ? ACCUM_WIDTH : DFW) + GAIN_WIDTH + 3;
	localparam int WW = PW - GAIN_FRAC;	// integer update
	localparam int DRW = WW + 1;

	logic signed [EW-1:0]          last_error_q;
	logic signed [ACCUM_WIDTH-1:0] error_accum_q;
	logic [OUT_WIDTH-1:0]          last_output_q;

	logic signed [EW-1:0]          err;
	logic signed [DFW-1:0]         diff;
	logic signed [SUMW-1:0]        sum_wide;
	logic signed [ACCUM_WIDTH-1:0] sum_sat;
	logic                          sum_ovf;
	logic                          integrate;
	logic signed [PW-1:0]          prod_p, prod_i, prod_d, prod_sum, prod_bias;
	logic signed [WW-1:0]          update;
	logic signed [DRW-1:0]         drive_full, lim_max, lim_min;
	logic [OUT_WIDTH-1:0]          drive_clamped;

	assign err  = EW'(measurement) - EW'(setpoint);
	assign diff = DFW'(err) - DFW'(last_error_q);

	// integrate only while the previous output sat strictly inside the limits
	assign integrate = (last_output_q < cfg.out_max) && (last_output_q > cfg.out_min);
	assign sum_wide  = integrate ? (SUMW'(error_accum_q) + SUMW'(err)) : SUMW'(error_accum_q);
	// upper bits disagree with the new sign bit: out of range, saturate
	assign sum_ovf = (sum_wide[SUMW-1:ACCUM_WIDTH-1] != {(SUMW-ACCUM_WIDTH+1){1'b0}})
		&& (sum_wide[SUMW-1:ACCUM_WIDTH-1] != {(SUMW-ACCUM_WIDTH+1){1'b1}});
	always_comb begin
		if (!sum_ovf)
			sum_sat = sum_wide[ACCUM_WIDTH-1:0];
		else if (sum_wide[SUMW-1])
			sum_sat = {1'b1, {(ACCUM_WIDTH-1){1'b0}}};
		else
			sum_sat = {1'b0, {(ACCUM_WIDTH-1){1'b1}}};
	end

	// three parallel gain products, 24 fraction bits each
	assign prod_p = PW'($signed({1'b0, cfg.kp_gain})) * PW'(err);
	assign prod_i = PW'($signed({1'b0, cfg.ki_gain})) * PW'(sum_sat);
	assign prod_d = PW'($signed({1'b0, cfg.kd_gain})) * PW'(diff);
	assign prod_sum = prod_p + prod_i + prod_d;

	// truncate toward zero: bias negative sums by one LSB below the integer
	assign prod_bias = prod_sum[PW-1] ? PW'({GAIN_FRAC{1'b1}}) : '0;
	always_comb begin
		logic signed [PW-1:0] biased;
		biased = prod_sum + prod_bias;
		update = biased[PW-1:GAIN_FRAC];
	end

	assign drive_full = DRW'(update) + DRW'($signed({1'b0, cfg.out_base}));
	assign lim_max    = DRW'($signed({1'b0, cfg.out_max}));
	assign lim_min    = DRW'($signed({1'b0, cfg.out_min}));

	// max clamp first, then min
	always_comb begin
		logic signed [DRW-1:0] t;
		t = (drive_full > lim_max) ? lim_max : drive_full;
		t = (t < lim_min) ? lim_min : t;
		drive_clamped = t[OUT_WIDTH-1:0];
	end

	assign drive_next = hold ? cfg.out_base : drive_clamped;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_error_q  <= '0;
			error_accum_q <= '0;
			last_output_q <= '0;
		end else if (step) begin
			last_output_q <= drive_next;
			if (!hold) begin
				last_error_q  <= err;
				error_accum_q <= sum_sat;
			end
		end
	end

endmodule

// ===== hdl/pid_controller_conditional_integral_core.sv =====
// Top level of the PID controller with conditional integration.
//
//  channel | direction | handshake             | payload
//  --------+-----------+-----------------------+------------------------------
//  in      | sink      | in_valid / in_ready   | measurement (signed), hold
//  out     | source    | out_valid / out_ready | drive (12 bits unsigned)
//  cfg     | sink      | cfg_valid / cfg_ready | cfg_index (3 bits), cfg_data
//
// One transaction per cycle sustained while out_ready is high. An input
// transaction lands in the input register; once the output register can
// take a result, the whole PID update (three parallel multiplies, sum,
// truncation, clamp) runs in one combinational pass into the output
// register, and the loop state updates at the same edge.
// Reset clears the state, the valid flags and loads the register defaults.
// A stalled output holds the input register; in_ready stays high whenever
// out_ready is high. Config writes are always ready.
module pid_controller_conditional_integral_core
	import pidci_pkg::*;
#(
	parameter int SAMPLE_WIDTH = 16,
	parameter int ACCUM_WIDTH = 32,
	localparam int CfgDataWidth = (SAMPLE_WIDTH > GAIN_WIDTH) ? SAMPLE_WIDTH : GAIN_WIDTH
) (
	input  logic                            clk,
	input  logic                            arst_n,
	// sample channel
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic signed [SAMPLE_WIDTH-1:0]  measurement,
	input  logic                            hold,
	// drive channel
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [OUT_WIDTH-1:0]            drive,
	// configuration write channel
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [REG_IDX_WIDTH-1:0]        cfg_index,
	input  logic [CfgDataWidth-1:0]         cfg_data
);

	ctrl_cfg_t                      cfg;
	logic signed [SAMPLE_WIDTH-1:0] setpoint;

	// input register stage
	logic                           valid_s1;
	logic signed [SAMPLE_WIDTH-1:0] measurement_s1;
	logic                           hold_s1;

	// output register
	logic                           out_valid_q;
	logic [OUT_WIDTH-1:0]           drive_q;

	logic                           advance;	// output register can take a result
	logic                           step;		// stage 1 item is processed this cycle
	logic [OUT_WIDTH-1:0]           drive_next;

	assign cfg_ready = 1'b1;

	assign advance  = !out_valid_q || out_ready;
	assign step     = valid_s1 && advance;
	assign in_ready = !valid_s1 || advance;

	pidci_cfg_regs #(
		.SAMPLE_WIDTH   (SAMPLE_WIDTH),
		.CFG_DATA_WIDTH (CfgDataWidth)
	) u_cfg_regs (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_valid (cfg_valid),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.setpoint  (setpoint)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			measurement_s1 <= measurement;
			hold_s1        <= hold;
		end
	end

	pidci_datapath #(
		.SAMPLE_WIDTH (SAMPLE_WIDTH),
		.ACCUM_WIDTH  (ACCUM_WIDTH)
	) u_datapath (
		.clk         (clk),
		.arst_n      (arst_n),
		.step        (step),
		.measurement (measurement_s1),
		.hold        (hold_s1),
		.cfg         (cfg),
		.setpoint    (setpoint),
		.drive_next  (drive_next)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (step) begin
			drive_q <= drive_next;
		end
	end

	assign out_valid = out_valid_q;
	assign drive     = drive_q;

endmodule

// ===== hdl/pidci_checker.sv =====
// Port-level assertions for the PID controller core, with its bind.
module pidci_checker
	import pidci_pkg::*;
(
	input logic                 clk,
	input logic                 arst_n,
	input logic                 in_valid,
	input logic                 in_ready,
	input logic                 hold,
	input logic                 out_valid,
	input logic                 out_ready,
	input logic [OUT_WIDTH-1:0] drive,
	input logic                 cfg_valid,
	input logic                 cfg_ready
);

	// a stalled result keeps its value
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(drive))
		else $error("drive changed while stalled");

	// a draining output never blocks the sample side
	a_no_bubble: assert property (@(posedge clk) disable iff (!arst_n)
		out_ready |-> in_ready)
		else $error("in_ready low while out_ready high");

	// an accepted item reaches the output unless the output is stalled
	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) ##1 (!out_valid || out_ready) |=> out_valid)
		else $error("result missing after accepted sample");

	// held samples pass through like any other
	a_hold_latency: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && hold) ##1 out_ready |=> out_valid)
		else $error("hold sample produced no result");

	a_cfg_ready: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_valid |-> cfg_ready)
		else $error("config write not taken");

endmodule

bind pid_controller_conditional_integral_core pidci_checker u_pidci_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_ready  (in_ready),
	.hold      (hold),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.drive     (drive),
	.cfg_valid (cfg_valid),
	.cfg_ready (cfg_ready)
);
